FILE: hw/rtl/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// Shared types, fixed-point widths and constants for the rotation matrix to
// Euler angle pipeline.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int IN_W          = 16;   // Q1.14 matrix element
    localparam int GUARD_SHIFT   = 8;    // Q1.14 -> Q1.22
    localparam int VEC_W         = 27;   // CORDIC x/y, headroom for gain and negation
    localparam int ANG_W         = 28;   // angle accumulator, 2^-24 rad units
    localparam int OUT_W         = 16;   // Q3.13 angle
    localparam int THR_W         = 15;
    localparam int TABLE_LEN     = 24;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int GAIN_W        = 30;
    localparam int GAIN_SHIFT    = 30;
    localparam int ROUND_SHIFT   = 11;   // 2^-24 -> 2^-13
    localparam int PROD_W        = VEC_W + GAIN_W + 1;
    localparam int RND_W         = ANG_W + 1 - ROUND_SHIFT;

    localparam logic [THR_W-1:0]        THR_RESET = THR_W'(1);
    localparam logic signed [ANG_W-1:0] PI_Q24    = ANG_W'(52707179);
    localparam logic [GAIN_W-1:0]       INV_GAIN  = GAIN_W'(652032874);
    localparam logic signed [RND_W-1:0] OUT_MAX   = RND_W'(25736);
    localparam logic signed [ANG_W:0]   RND_BIAS  = (ANG_W+1)'(1024);

    localparam logic signed [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        ANG_W'(13176795), ANG_W'(7778716), ANG_W'(4110060), ANG_W'(2086331),
        ANG_W'(1047214),  ANG_W'(524117),  ANG_W'(262123),  ANG_W'(131069),
        ANG_W'(65536),    ANG_W'(32768),   ANG_W'(16384),   ANG_W'(8192),
        ANG_W'(4096),     ANG_W'(2048),    ANG_W'(1024),    ANG_W'(512),
        ANG_W'(256),      ANG_W'(128),     ANG_W'(64),      ANG_W'(32),
        ANG_W'(16),       ANG_W'(8),       ANG_W'(4),       ANG_W'(2)
    };

    typedef struct packed {
        logic signed [IN_W-1:0] r00;
        logic signed [IN_W-1:0] r10;
        logic signed [IN_W-1:0] r20;
        logic signed [IN_W-1:0] r21;
        logic signed [IN_W-1:0] r22;
        logic signed [IN_W-1:0] r11;
        logic signed [IN_W-1:0] r12;
    } mat_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] roll_angle;
        logic signed [OUT_W-1:0] pitch_angle;
        logic signed [OUT_W-1:0] yaw_angle;
        logic                    singular;
    } euler_t;

    // Round a 2^-24 rad angle to Q3.13 and clamp to +-pi.
    function automatic logic signed [OUT_W-1:0] round_angle(
        input logic signed [ANG_W-1:0] z
    );
        logic signed [ANG_W:0]   s;
        logic signed [RND_W-1:0] r;
        s = {z[ANG_W-1], z} + RND_BIAS;
        r = $signed(s[ANG_W:ROUND_SHIFT]);
        if (r > OUT_MAX)
            r = OUT_MAX;
        else if (r < -OUT_MAX)
            r = -OUT_MAX;
        return r[OUT_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/rme_stream_if.sv
// ----------------------------------------------------------------------------
// rme_stream_if
// Valid/ready stream carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface rme_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rme_cordic_stage.sv
// ----------------------------------------------------------------------------
// rme_cordic_stage
// One registered CORDIC vectoring micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module rme_cordic_stage #(
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 1
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [rme_pkg::VEC_W-1:0] x_in,
    input  logic signed [rme_pkg::VEC_W-1:0] y_in,
    input  logic signed [rme_pkg::ANG_W-1:0] z_in,
    input  logic                             zero_in,
    input  logic        [SIDE_W-1:0]         side_in,
    output logic signed [rme_pkg::VEC_W-1:0] x_out,
    output logic signed [rme_pkg::VEC_W-1:0] y_out,
    output logic signed [rme_pkg::ANG_W-1:0] z_out,
    output logic                             zero_out,
    output logic        [SIDE_W-1:0]         side_out
);
    localparam logic signed [rme_pkg::ANG_W-1:0] ANGLE = rme_pkg::ATAN_TAB[SHIFT];

    logic signed [rme_pkg::VEC_W-1:0] x_reg, x_next;
    logic signed [rme_pkg::VEC_W-1:0] y_reg, y_next;
    logic signed [rme_pkg::ANG_W-1:0] z_reg, z_next;
    logic signed [rme_pkg::VEC_W-1:0] dx, dy;
    logic                             zero_reg;
    logic        [SIDE_W-1:0]         side_reg;

    assign dx = y_in >>> SHIFT;
    assign dy = x_in >>> SHIFT;

    always_comb
    begin
        // rotate toward the x axis
        if (!y_in[rme_pkg::VEC_W-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANGLE;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            zero_reg <= zero_in;
            side_reg <= side_in;
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign zero_out = zero_reg;
    assign side_out = side_reg;
endmodule

FILE: hw/rtl/rme_cordic.sv
// ----------------------------------------------------------------------------
// rme_cordic
// Pipelined CORDIC vectoring: a quadrant fold stage, then one register stage
// per micro-rotation. Gives scaled magnitude and atan2(y, x).
// ----------------------------------------------------------------------------
module rme_cordic #(
    parameter int CORDIC_STAGES = rme_pkg::CORDIC_STAGES_DEF,
    parameter int SIDE_W        = 1
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [rme_pkg::VEC_W-1:0] x_in,
    input  logic signed [rme_pkg::VEC_W-1:0] y_in,
    input  logic        [SIDE_W-1:0]         side_in,
    output logic signed [rme_pkg::VEC_W-1:0] mag,
    output logic signed [rme_pkg::ANG_W-1:0] ang,
    output logic        [SIDE_W-1:0]         side_out
);
    localparam int NSTG = (CORDIC_STAGES < rme_pkg::TABLE_LEN) ?
                          CORDIC_STAGES : rme_pkg::TABLE_LEN;

    logic signed [rme_pkg::VEC_W-1:0] xs [NSTG+1];
    logic signed [rme_pkg::VEC_W-1:0] ys [NSTG+1];
    logic signed [rme_pkg::ANG_W-1:0] zs [NSTG+1];
    logic                             zs_zero [NSTG+1];
    logic        [SIDE_W-1:0]         sides [NSTG+1];

    logic signed [rme_pkg::VEC_W-1:0] x0_reg, x0_next;
    logic signed [rme_pkg::VEC_W-1:0] y0_reg, y0_next;
    logic signed [rme_pkg::ANG_W-1:0] z0_reg, z0_next;
    logic                             zero0_reg;
    logic        [SIDE_W-1:0]         side0_reg;

    always_comb
    begin
        // fold the left half plane onto the right, start angle at +-pi
        if (x_in[rme_pkg::VEC_W-1])
        begin
            x0_next = -x_in;
            y0_next = -y_in;
            z0_next = y_in[rme_pkg::VEC_W-1] ? -rme_pkg::PI_Q24 : rme_pkg::PI_Q24;
        end
        else
        begin
            x0_next = x_in;
            y0_next = y_in;
            z0_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg    <= x0_next;
            y0_reg    <= y0_next;
            z0_reg    <= z0_next;
            zero0_reg <= (x_in == '0) && (y_in == '0);
            side0_reg <= side_in;
        end
    end

    assign xs[0]      = x0_reg;
    assign ys[0]      = y0_reg;
    assign zs[0]      = z0_reg;
    assign zs_zero[0] = zero0_reg;
    assign sides[0]   = side0_reg;

    for (genvar i = 0; i < NSTG; i++)
    begin : g_stage
        rme_cordic_stage #(
            .SHIFT  (i),
            .SIDE_W (SIDE_W)
        ) u_stage (
            .clk      (clk),
            .en       (en),
            .x_in     (xs[i]),
            .y_in     (ys[i]),
            .z_in     (zs[i]),
            .zero_in  (zs_zero[i]),
            .side_in  (sides[i]),
            .x_out    (xs[i+1]),
            .y_out    (ys[i+1]),
            .z_out    (zs[i+1]),
            .zero_out (zs_zero[i+1]),
            .side_out (sides[i+1])
        );
    end

    assign mag      = xs[NSTG];
    assign ang      = zs_zero[NSTG] ? '0 : zs[NSTG];
    assign side_out = sides[NSTG];
endmodule

FILE: hw/rtl/rotation_matrix_to_euler_core.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_core
// Z-Y-X Euler angles from a Q1.14 rotation matrix using pipelined CORDIC.
//
//  channel   dir  handshake        payload
//  mat       in   valid / ready    r00 r10 r20 r21 r22 r11 r12 (Q1.14)
//  euler     out  valid / ready    roll/pitch/yaw (Q3.13), singular
//  cfg       in   cfg_we           cfg_wdata -> singular_threshold
//
//  One matrix per cycle while the pipe is not stalled. A result passes the
//  yaw/roll CORDIC pipe, the gain multiply, the pitch CORDIC pipe (it needs
//  sy), the rounding stage and the output register.
//  rst_n clears all valid bits and sets the threshold to 1.
//  The output register holds a result until it is taken; the pipe keeps
//  moving into it and stalls as a whole only when both are full.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_core #(
    parameter int CORDIC_STAGES = rme_pkg::CORDIC_STAGES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rme_stream_if.sink                  mat,
    rme_stream_if.source                euler,
    input  logic                        cfg_we,
    input  logic [rme_pkg::THR_W-1:0]   cfg_wdata
);
    localparam int NSTG   = (CORDIC_STAGES < rme_pkg::TABLE_LEN) ?
                            CORDIC_STAGES : rme_pkg::TABLE_LEN;
    localparam int CPIPE  = NSTG + 1;
    localparam int DEPTH  = 2 * CPIPE + 2;
    localparam int SIDE_P = 1 + 2 * rme_pkg::ANG_W;
    localparam int VEC_W  = rme_pkg::VEC_W;
    localparam int ANG_W  = rme_pkg::ANG_W;
    localparam int IN_W   = rme_pkg::IN_W;

    logic [rme_pkg::THR_W-1:0] thr_reg;
    logic [DEPTH-1:0]          vld_reg, vld_next;
    logic                      en;
    logic                      out_load;
    logic                      out_vld_reg;
    rme_pkg::euler_t           out_reg;
    rme_pkg::euler_t           res_reg, res_next;

    // ---------------- flow control ----------------
    assign out_load = !out_vld_reg || euler.ready;
    assign en       = !vld_reg[DEPTH-1] || out_load;
    assign mat.ready = en;

    assign vld_next = {vld_reg[DEPTH-2:0], mat.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
            thr_reg     <= rme_pkg::THR_RESET;
        end
        else
        begin
            if (en)
                vld_reg <= vld_next;
            if (out_load)
                out_vld_reg <= vld_reg[DEPTH-1];
            if (cfg_we)
                thr_reg <= cfg_wdata;
        end
    end

    // ---------------- yaw and both roll candidates ----------------
    function automatic logic signed [VEC_W-1:0] widen(input logic signed [IN_W-1:0] v);
        return VEC_W'(v) <<< rme_pkg::GUARD_SHIFT;
    endfunction

    logic signed [VEC_W-1:0] yaw_mag;
    logic signed [ANG_W-1:0] yaw_z, rollr_z, rolls_z;
    logic        [IN_W-1:0]  r20_a;

    rme_cordic #(.CORDIC_STAGES (CORDIC_STAGES), .SIDE_W (IN_W)) u_yaw (
        .clk      (clk),
        .en       (en),
        .x_in     (widen(mat.data.r00)),
        .y_in     (widen(mat.data.r10)),
        .side_in  (mat.data.r20),
        .mag      (yaw_mag),
        .ang      (yaw_z),
        .side_out (r20_a)
    );

    rme_cordic #(.CORDIC_STAGES (CORDIC_STAGES), .SIDE_W (1)) u_roll_reg (
        .clk      (clk),
        .en       (en),
        .x_in     (widen(mat.data.r22)),
        .y_in     (widen(mat.data.r21)),
        .side_in  (1'b0),
        .mag      (),
        .ang      (rollr_z),
        .side_out ()
    );

    rme_cordic #(.CORDIC_STAGES (CORDIC_STAGES), .SIDE_W (1)) u_roll_sing (
        .clk      (clk),
        .en       (en),
        .x_in     (widen(mat.data.r11)),
        .y_in     (-widen(mat.data.r12)),
        .side_in  (1'b0),
        .mag      (),
        .ang      (rolls_z),
        .side_out ()
    );

    // ---------------- gain correction of sy ----------------
    logic signed [rme_pkg::PROD_W-1:0] prod_reg;
    logic signed [ANG_W-1:0]           yawz_m_reg, rollr_m_reg, rolls_m_reg;
    logic        [IN_W-1:0]            r20_m_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= yaw_mag * $signed({1'b0, rme_pkg::INV_GAIN});
            yawz_m_reg  <= yaw_z;
            rollr_m_reg <= rollr_z;
            rolls_m_reg <= rolls_z;
            r20_m_reg   <= r20_a;
        end
    end

    logic signed [VEC_W-1:0] sy;
    logic signed [VEC_W-1:0] thr_q22;
    logic                    sing;
    logic [SIDE_P-1:0]       side_p_in, side_p_out;
    logic signed [ANG_W-1:0] pitch_z;

    assign sy      = prod_reg[rme_pkg::GAIN_SHIFT +: VEC_W];
    assign thr_q22 = $signed({{(VEC_W - rme_pkg::THR_W - rme_pkg::GUARD_SHIFT){1'b0}},
                              thr_reg, {rme_pkg::GUARD_SHIFT{1'b0}}});
    assign sing    = sy < thr_q22;

    // pick the roll source and zero yaw when singular, carry both past the pitch pipe
    assign side_p_in = {sing,
                        sing ? rolls_m_reg : rollr_m_reg,
                        sing ? {ANG_W{1'b0}} : yawz_m_reg};

    rme_cordic #(.CORDIC_STAGES (CORDIC_STAGES), .SIDE_W (SIDE_P)) u_pitch (
        .clk      (clk),
        .en       (en),
        .x_in     (sy),
        .y_in     (-widen(r20_m_reg)),
        .side_in  (side_p_in),
        .mag      (),
        .ang      (pitch_z),
        .side_out (side_p_out)
    );

    // ---------------- rounding and output ----------------
    always_comb
    begin
        res_next.roll_angle  = rme_pkg::round_angle(side_p_out[ANG_W +: ANG_W]);
        res_next.pitch_angle = rme_pkg::round_angle(pitch_z);
        res_next.yaw_angle   = rme_pkg::round_angle(side_p_out[0 +: ANG_W]);
        res_next.singular    = side_p_out[SIDE_P-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
        if (out_load)
            out_reg <= res_reg;
    end

    assign euler.valid = out_vld_reg;
    assign euler.data  = out_reg;

    // ---------------- assertions ----------------
    a_in_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (mat.valid && mat.ready) |=> vld_reg[0])
        else $error("accepted matrix did not enter the pipe");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !en |-> (vld_reg[DEPTH-1] && out_vld_reg && !euler.ready))
        else $error("pipe stalled with room downstream");

    a_sing_yaw: assert property (@(posedge clk) disable iff (!rst_n)
        (euler.valid && euler.data.singular) |-> (euler.data.yaw_angle == '0))
        else $error("yaw not zero on singular result");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler.valid |-> (euler.data.roll_angle  <= 16'sd25736 &&
                         euler.data.roll_angle  >= -16'sd25736 &&
                         euler.data.pitch_angle <= 16'sd25736 &&
                         euler.data.pitch_angle >= -16'sd25736))
        else $error("angle beyond pi");
endmodule
